// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty bodies when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// ----- hw/rtl/ffud_pkg.sv -----
// Shared types, character codes and helpers for the form field decoder.
package ffud_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    typedef enum logic [1:0] {
        PH_KEY  = 2'd0,
        PH_VAL  = 2'd1,
        PH_ESC1 = 2'd2,
        PH_ESC2 = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_KEYCH  = 3'd0,
        KIND_VALCH  = 3'd1,
        KIND_FIELD  = 3'd2,
        KIND_END    = 3'd3,
        KIND_ENDKEY = 3'd4
    } kind_t;

    // One queued command: first result, and whether a text end follows it.
    typedef struct packed {
        logic       pair;
        logic [7:0] ch;
        kind_t      kind;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Lax hex digit weight, all 8 bits kept; the second digit is OR-ed in whole.
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c <= CH_NINE)
                v = c - CH_ZERO;
            else if (c <= CH_UPPER_Z)
                v = c - CH_UPPER_A + DIGIT_TEN;
            else
                v = c - CH_LOWER_A + DIGIT_TEN;
            digit_value = v;
        end
    endfunction

endpackage

// ----- hw/rtl/ffud_front.sv -----
// Front end: accepts text bytes, tracks parse phase, queues result commands.
module ffud_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  ffud_pkg::q_stat_t q_stat,
    output logic              push,
    output ffud_pkg::cmd_t    push_cmd
);

    ffud_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       high_reg, high_next;
    logic             keyp_reg, keyp_next;
    logic             has_result;
    logic             accept;
    logic [7:0]       dig;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && has_result;
    assign dig      = ffud_pkg::digit_value(in_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ffud_pkg::PH_KEY;
            high_reg  <= '0;
            keyp_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
            keyp_reg  <= keyp_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        high_next      = high_reg;
        keyp_next      = keyp_reg;
        has_result     = 1'b0;
        push_cmd.pair  = 1'b0;
        push_cmd.ch    = '0;
        push_cmd.kind  = ffud_pkg::KIND_KEYCH;
        if (in_byte == ffud_pkg::CH_NUL)
        begin
            has_result = 1'b1;
            if (phase_reg == ffud_pkg::PH_KEY)
                push_cmd.kind = keyp_reg ? ffud_pkg::KIND_ENDKEY : ffud_pkg::KIND_END;
            else
            begin
                push_cmd.kind = ffud_pkg::KIND_FIELD;
                push_cmd.pair = 1'b1;
            end
            phase_next = ffud_pkg::PH_KEY;
            high_next  = '0;
            keyp_next  = 1'b0;
        end
        else if (phase_reg == ffud_pkg::PH_KEY)
        begin
            if (in_byte == ffud_pkg::CH_EQUALS)
            begin
                phase_next = ffud_pkg::PH_VAL;
                keyp_next  = 1'b0;
            end
            else
            begin
                has_result  = 1'b1;
                push_cmd.ch = in_byte;
                keyp_next   = 1'b1;
            end
        end
        else if (in_byte == ffud_pkg::CH_AMP)
        begin
            // also drops an unfinished escape
            has_result    = 1'b1;
            push_cmd.kind = ffud_pkg::KIND_FIELD;
            phase_next    = ffud_pkg::PH_KEY;
            keyp_next     = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                ffud_pkg::PH_VAL:
                begin
                    if (in_byte == ffud_pkg::CH_PERCENT)
                        phase_next = ffud_pkg::PH_ESC1;
                    else
                    begin
                        has_result    = 1'b1;
                        push_cmd.kind = ffud_pkg::KIND_VALCH;
                        push_cmd.ch   = (in_byte == ffud_pkg::CH_PLUS) ?
                                        ffud_pkg::CH_SPACE : in_byte;
                    end
                end
                ffud_pkg::PH_ESC1:
                begin
                    // only the low nibble of the first digit survives the shift
                    high_next  = dig[3:0];
                    phase_next = ffud_pkg::PH_ESC2;
                end
                ffud_pkg::PH_ESC2:
                begin
                    has_result    = 1'b1;
                    push_cmd.kind = ffud_pkg::KIND_VALCH;
                    push_cmd.ch   = {high_reg, 4'h0} | dig;
                    phase_next    = ffud_pkg::PH_VAL;
                end
                default:
                begin
                    phase_next = ffud_pkg::PH_KEY;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/ffud_queue.sv -----
// Small command queue between the front and back ends.
module ffud_queue
#(
    parameter int DEPTH = ffud_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ffud_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output ffud_pkg::cmd_t    head_cmd,
    output ffud_pkg::q_stat_t q_stat
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ffud_pkg::cmd_t   slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat       = '{full:  (count_reg == CNT_W'(DEPTH)),
                            empty: (count_reg == '0)};
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_cmd     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- hw/rtl/ffud_back.sv -----
// Back end: expands queued commands into result items behind an output register.
module ffud_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  ffud_pkg::q_stat_t q_stat,
    input  ffud_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic [2:0]        out_kind,
    output logic              out_last
);

    logic             valid_reg;
    logic [7:0]       char_reg;
    ffud_pkg::kind_t  kind_reg;
    logic             last_reg;
    logic             pend_reg;
    logic             load;

    assign load      = !valid_reg || out_ready;
    // the trailing text end of a pair goes out before the next command
    assign pop       = load && !pend_reg && !q_stat.empty;
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= !q_stat.empty;
                pend_reg  <= !q_stat.empty && head_cmd.pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                char_reg <= '0;
                kind_reg <= ffud_pkg::KIND_END;
                last_reg <= 1'b1;
            end
            else
            begin
                char_reg <= head_cmd.ch;
                kind_reg <= head_cmd.kind;
                last_reg <= !head_cmd.pair;
            end
        end
    end

endmodule

// ----- hw/rtl/form_field_url_decoder_unit.sv -----
// Top level of the posted form text decoder.
//
// channel   dir  payload
// s_axis    in   tdata[7:0] text_byte
// m_axis    out  tdata[7:0] out_char, tuser[2:0] item_kind, tlast last_of_run
//
// One byte is taken per cycle while the command queue has room; the front end
// updates the parse phase in that same cycle. Results leave at one per cycle
// from the output register while the sink is ready; a byte with two results holds
// the back end until both are out. Results are queued, then registered for output.
// Reset (rst_n low, asynchronous) empties the queue and returns to key phase.
// An output stall backs up the queue and then drops s_axis_tready.
`include "assert_macros.svh"
module form_field_url_decoder_unit
#(
    parameter int QUEUE_DEPTH = ffud_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [2:0] m_axis_tuser,   // [2:0] item_kind
    output logic       m_axis_tlast
);

    ffud_pkg::q_stat_t q_stat;
    ffud_pkg::cmd_t    push_cmd;
    ffud_pkg::cmd_t    head_cmd;
    logic              push;
    logic              pop;

    ffud_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ffud_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    ffud_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // only a field end that precedes a text end is not last of its byte
    `ASSERT_IMPLIES(a_nonlast_is_field, clk, rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == ffud_pkg::KIND_FIELD)
    `ASSERT_NEXT(a_pair_follows, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast && m_axis_tuser == ffud_pkg::KIND_END)
    `ASSERT_IMPLIES(a_marks_zero, clk, rst_n, m_axis_tvalid && (m_axis_tuser == ffud_pkg::KIND_FIELD || m_axis_tuser == ffud_pkg::KIND_END || m_axis_tuser == ffud_pkg::KIND_ENDKEY), m_axis_tdata == 8'h00)

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the posted form text decoder: directed table, random form texts, self-checking.
`timescale 1ns / 100ps

module tb_top;

    import ffud_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
        logic       last;
    } decoded_t;

    // typed: expectation written in the row; n results, first char/kind given,
    // a second result is always the text end
    typedef struct packed {
        logic [7:0] txt;
        logic       typed;
        logic [1:0] n;
        logic [7:0] c0;
        kind_t      k0;
    } dir_row_t;

    localparam int DIR_ROWS    = 26;
    localparam int PHASE_BYTES = 450;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic [2:0] m_axis_tuser;           // [2:0] item_kind
    logic       m_axis_tlast;

    // predictor state
    phase_t     text_phase = PH_KEY;
    logic [7:0] esc_high = 8'h00;
    logic       key_open = 1'b0;

    decoded_t   decoded_q[$];
    dir_row_t   dir_rows[DIR_ROWS];
    int         err_count = 0;
    int         bytes_sent = 0;
    int         src_idle_pct = 10;
    int         sink_idle_pct = 84;

    form_field_url_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // lax digit weight, full 8 bits kept
    function automatic logic [7:0] hex_weight(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c <= CH_NINE)
                v = c - CH_ZERO;
            else if (c <= CH_UPPER_Z)
                v = c - CH_UPPER_A + DIGIT_TEN;
            else
                v = c - CH_LOWER_A + DIGIT_TEN;
            return v;
        end
    endfunction

    function automatic int decode_text_byte(input logic [7:0] b,
                                            output decoded_t r0, output decoded_t r1);
        int         n;
        logic [7:0] lo;
        begin
            n = 0;
            r0 = '0;
            r1 = '0;
            if (b == CH_NUL) begin
                if (text_phase == PH_KEY) begin
                    r0 = '{CH_NUL, key_open ? KIND_ENDKEY : KIND_END, 1'b1};
                    n = 1;
                end
                else begin
                    r0 = '{CH_NUL, KIND_FIELD, 1'b0};
                    r1 = '{CH_NUL, KIND_END, 1'b1};
                    n = 2;
                end
                text_phase = PH_KEY;
                esc_high = 8'h00;
                key_open = 1'b0;
            end
            else if (text_phase == PH_KEY) begin
                if (b == CH_EQUALS) begin
                    text_phase = PH_VAL;
                    key_open = 1'b0;
                end
                else begin
                    r0 = '{b, KIND_KEYCH, 1'b1};
                    n = 1;
                    key_open = 1'b1;
                end
            end
            else if (b == CH_AMP) begin
                // also drops an unfinished escape
                r0 = '{CH_NUL, KIND_FIELD, 1'b1};
                n = 1;
                text_phase = PH_KEY;
                key_open = 1'b0;
            end
            else if (text_phase == PH_VAL) begin
                if (b == CH_PLUS) begin
                    r0 = '{CH_SPACE, KIND_VALCH, 1'b1};
                    n = 1;
                end
                else if (b == CH_PERCENT)
                    text_phase = PH_ESC1;
                else begin
                    r0 = '{b, KIND_VALCH, 1'b1};
                    n = 1;
                end
            end
            else if (text_phase == PH_ESC1) begin
                esc_high = hex_weight(b);
                text_phase = PH_ESC2;
            end
            else begin
                // second weight is OR-ed in whole, not just its low nibble
                lo = hex_weight(b);
                r0 = '{{esc_high[3:0], 4'h0} | lo, KIND_VALCH, 1'b1};
                n = 1;
                text_phase = PH_VAL;
            end
            return n;
        end
    endfunction

    function automatic dir_row_t typed_row(input logic [7:0] txt, input logic [1:0] n,
                                           input logic [7:0] c0, input kind_t k0);
        return '{txt, 1'b1, n, c0, k0};
    endfunction

    function automatic dir_row_t pred_row(input logic [7:0] txt);
        return '{txt, 1'b0, 2'd0, CH_NUL, KIND_KEYCH};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
            err_count++;
        end
    endtask

    // entered and left at a falling edge; returns once the request is taken
    task automatic send_text_byte(input logic [7:0] b);
        begin
            while ($urandom_range(99) < src_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= b;
            do
                @(posedge clk);
            while (!s_axis_tready);
            bytes_sent++;
            @(negedge clk);
        end
    endtask

    task automatic feed_byte(input logic [7:0] b);
        decoded_t r0, r1;
        int       n;
        begin
            send_text_byte(b);
            n = decode_text_byte(b, r0, r1);
            if (n > 0)
                decoded_q.push_back(r0);
            if (n > 1)
                decoded_q.push_back(r1);
        end
    endtask

    function automatic logic [7:0] hex_char();
        int k;
        begin
            k = $urandom_range(21);
            if ($urandom_range(99) < 15)
                return 8'($urandom_range(1, 255));
            if (k < 10)
                return CH_ZERO + 8'(k);
            if (k < 16)
                return CH_LOWER_A + 8'(k - 10);
            return CH_UPPER_A + 8'(k - 16);
        end
    endfunction

    function automatic logic [7:0] key_char();
        logic [7:0] v;
        begin
            if ($urandom_range(99) < 70)
                return CH_LOWER_A + 8'($urandom_range(25));
            v = 8'($urandom_range(1, 255));
            return (v == CH_EQUALS) ? CH_AMP : v;
        end
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] v;
        begin
            if ($urandom_range(99) < 70)
                return CH_UPPER_A + 8'($urandom_range(25));
            v = 8'($urandom_range(1, 255));
            if (v == CH_AMP || v == CH_PERCENT || v == CH_PLUS)
                v = CH_EQUALS;
            return v;
        end
    endfunction

    // one well-formed text with random content, now and then cut short
    task automatic send_form_text();
        int nfields;
        int vlen;
        int sel;
        bit cut;
        begin
            nfields = $urandom_range(1, 4);
            cut = 1'b0;
            for (int f = 0; f < nfields && !cut; f++) begin
                if (f > 0)
                    feed_byte(CH_AMP);
                repeat ($urandom_range(0, 6))
                    feed_byte(key_char());
                if ($urandom_range(9) != 0) begin
                    feed_byte(CH_EQUALS);
                    vlen = $urandom_range(0, 8);
                    for (int t = 0; t < vlen && !cut; t++) begin
                        sel = $urandom_range(99);
                        if (sel < 60)
                            feed_byte(value_char());
                        else if (sel < 75)
                            feed_byte(CH_PLUS);
                        else if (sel < 95) begin
                            feed_byte(CH_PERCENT);
                            feed_byte(hex_char());
                            feed_byte(hex_char());
                        end
                        else begin
                            feed_byte(CH_PERCENT);
                            if ($urandom_range(1))
                                feed_byte(hex_char());
                            if ($urandom_range(1)) begin
                                feed_byte(CH_NUL);
                                cut = 1'b1;
                            end
                            else begin
                                feed_byte(CH_AMP);
                                t = vlen;
                            end
                        end
                    end
                end
            end
            if (!cut)
                feed_byte(CH_NUL);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        decoded_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0)
                report_mismatch("unexpected result", {m_axis_tdata, m_axis_tuser}, 0);
            else begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.ch)
                    report_mismatch("out_char", m_axis_tdata, want.ch);
                if (m_axis_tuser !== want.kind)
                    report_mismatch("item_kind", m_axis_tuser, want.kind);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_run", m_axis_tlast, want.last);
            end
        end
    end

    initial
    begin
        decoded_t r0, r1;
        int       n;
        dir_rows[0]  = typed_row(CH_NUL, 2'd1, CH_NUL, KIND_END);
        dir_rows[1]  = typed_row(8'h61, 2'd1, 8'h61, KIND_KEYCH);
        dir_rows[2]  = typed_row(8'hFF, 2'd1, 8'hFF, KIND_KEYCH);
        dir_rows[3]  = typed_row(CH_AMP, 2'd1, CH_AMP, KIND_KEYCH);  // '&' inside a key
        dir_rows[4]  = typed_row(CH_NUL, 2'd1, CH_NUL, KIND_ENDKEY);
        dir_rows[5]  = typed_row(CH_EQUALS, 2'd0, CH_NUL, KIND_KEYCH);
        dir_rows[6]  = typed_row(CH_PLUS, 2'd1, CH_SPACE, KIND_VALCH);
        dir_rows[7]  = typed_row(CH_EQUALS, 2'd1, CH_EQUALS, KIND_VALCH);
        dir_rows[8]  = typed_row(CH_PERCENT, 2'd0, CH_NUL, KIND_KEYCH);
        dir_rows[9]  = pred_row(8'h34);
        dir_rows[10] = pred_row(8'h31);
        dir_rows[11] = typed_row(CH_PERCENT, 2'd0, CH_NUL, KIND_KEYCH);
        dir_rows[12] = pred_row(8'h66);
        dir_rows[13] = pred_row(8'h46);
        dir_rows[14] = typed_row(CH_PERCENT, 2'd0, CH_NUL, KIND_KEYCH);
        dir_rows[15] = pred_row(8'hFF);
        dir_rows[16] = pred_row(8'h7A);
        dir_rows[17] = typed_row(CH_PERCENT, 2'd0, CH_NUL, KIND_KEYCH);
        // escape cut short by '&'
        dir_rows[18] = typed_row(CH_AMP, 2'd1, CH_NUL, KIND_FIELD);
        dir_rows[19] = typed_row(8'h6B, 2'd1, 8'h6B, KIND_KEYCH);
        dir_rows[20] = typed_row(CH_EQUALS, 2'd0, CH_NUL, KIND_KEYCH);
        dir_rows[21] = typed_row(CH_PERCENT, 2'd0, CH_NUL, KIND_KEYCH);
        dir_rows[22] = pred_row(CH_NINE);
        // escape cut short by the text end
        dir_rows[23] = typed_row(CH_NUL, 2'd2, CH_NUL, KIND_FIELD);
        dir_rows[24] = typed_row(CH_EQUALS, 2'd0, CH_NUL, KIND_KEYCH);
        dir_rows[25] = typed_row(CH_NUL, 2'd2, CH_NUL, KIND_FIELD);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_text_byte(dir_rows[i].txt);
            n = decode_text_byte(dir_rows[i].txt, r0, r1);
            if (dir_rows[i].typed) begin
                n = dir_rows[i].n;
                r0 = '{dir_rows[i].c0, dir_rows[i].k0, n == 1};
                r1 = '{CH_NUL, KIND_END, 1'b1};
            end
            if (n > 0)
                decoded_q.push_back(r0);
            if (n > 1)
                decoded_q.push_back(r1);
        end

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 84 : 0;
            sink_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 10 : 0;
            while (bytes_sent < DIR_ROWS + (ph + 1) * PHASE_BYTES) begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 8))
                        feed_byte(8'($urandom_range(0, 255)));
                else
                    send_form_text();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
